// File: rtl/steering_seek_arrive_assert.svh
// Assertion macros for the steering block's top-level RTL file.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef STEERING_SEEK_ARRIVE_ASSERT_SVH
`define STEERING_SEEK_ARRIVE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SSA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define SSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define SSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ssa_pkg.sv
// Shared constants for the seek / arrive steering block.
// No dependencies; used by the steering top level.
package ssa_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int SPEED_WIDTH = 31;
    localparam int DECEL_WIDTH = 2;

    localparam logic ACT_SEEK   = 1'b0;
    localparam logic ACT_ARRIVE = 1'b1;

    localparam logic [DECEL_WIDTH-1:0] DECEL_NONE   = 2'd0;
    localparam logic [DECEL_WIDTH-1:0] DECEL_FAST   = 2'd1;
    localparam logic [DECEL_WIDTH-1:0] DECEL_NORMAL = 2'd2;
    localparam logic [DECEL_WIDTH-1:0] DECEL_SLOW   = 2'd3;

    // floor(x / 3) = (x * DIV3_MAGIC) >> DIV3_SHIFT for every 32-bit x.
    localparam logic [31:0] DIV3_MAGIC = 32'hAAAA_AAAB;
    localparam int          DIV3_SHIFT = 33;

endpackage

// File: rtl/ssa_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Uses no package items; instantiated by the steering top level.
module ssa_isqrt #(
    parameter int RW  = 33,
    parameter int SBW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RW-1:0]   i_sq,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_valid,
    output logic [RW-1:0]     o_root,
    output logic [SBW-1:0]    o_sb
);

    localparam int SW = 2 * RW;
    localparam int MW = RW + 1;
    localparam int TW = MW + 2;

    logic           r_v    [RW];
    logic [MW-1:0]  r_rem  [RW];
    logic [RW-1:0]  r_root [RW];
    logic [SW-1:0]  r_s    [RW];
    logic [SBW-1:0] r_sb   [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        logic           pv;
        logic [MW-1:0]  prem;
        logic [RW-1:0]  proot;
        logic [SW-1:0]  ps;
        logic [SBW-1:0] psb;
        logic [TW-1:0]  t;
        logic [TW-1:0]  trial;
        logic           take;

        if (j == 0) begin : g_first
            assign pv    = i_valid;
            assign prem  = '0;
            assign proot = '0;
            assign ps    = i_sq;
            assign psb   = i_sb;
        end else begin : g_next
            assign pv    = r_v[j-1];
            assign prem  = r_rem[j-1];
            assign proot = r_root[j-1];
            assign ps    = r_s[j-1];
            assign psb   = r_sb[j-1];
        end

        // Bring down the next pair of radicand bits and try root bit one.
        assign t     = {prem, ps[SW-1 -: 2]};
        assign trial = TW'({proot, 2'b01});
        assign take  = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= take ? MW'(t - trial) : MW'(t);
                r_root[j] <= {proot[RW-2:0], take};
                r_s[j]    <= {ps[SW-3:0], 2'b00};
                r_sb[j]   <= psb;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_sb    = r_sb[RW-1];

endmodule

// File: rtl/ssa_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Uses no package items; the quotient must fit in QW bits.
module ssa_div #(
    parameter int DW  = 33,
    parameter int QW  = 31,
    parameter int SBW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DW+QW-2:0]  i_num,
    input  logic [DW-1:0]     i_den,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_valid,
    output logic [QW-1:0]     o_quo,
    output logic [SBW-1:0]    o_sb
);

    localparam int NW = DW - 1 + QW;

    logic           r_v   [QW];
    logic [DW-1:0]  r_rem [QW];
    logic [QW-1:0]  r_low [QW];
    logic [QW-1:0]  r_quo [QW];
    logic [DW-1:0]  r_den [QW];
    logic [SBW-1:0] r_sb  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic           pv;
        logic [DW-1:0]  prem;
        logic [QW-1:0]  plow;
        logic [QW-1:0]  pquo;
        logic [DW-1:0]  pden;
        logic [SBW-1:0] psb;
        logic [DW:0]    t;
        logic           take;

        if (j == 0) begin : g_first
            assign pv   = i_valid;
            assign prem = DW'(i_num[NW-1:QW]);
            assign plow = i_num[QW-1:0];
            assign pquo = '0;
            assign pden = i_den;
            assign psb  = i_sb;
        end else begin : g_next
            assign pv   = r_v[j-1];
            assign prem = r_rem[j-1];
            assign plow = r_low[j-1];
            assign pquo = r_quo[j-1];
            assign pden = r_den[j-1];
            assign psb  = r_sb[j-1];
        end

        assign t    = {prem, plow[QW-1]};
        assign take = (t >= {1'b0, pden});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? DW'(t - {1'b0, pden}) : DW'(t);
                r_low[j] <= {plow[QW-2:0], 1'b0};
                r_quo[j] <= {pquo[QW-2:0], take};
                r_den[j] <= pden;
                r_sb[j]  <= psb;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_sb    = r_sb[QW-1];

endmodule

// File: rtl/steering_seek_arrive.sv
// Seek / arrive steering force, top level of the deep pipeline.
// Depends on ssa_pkg, ssa_isqrt, ssa_div and steering_seek_arrive_assert.svh.
//
// Usage: present one query word (mode, target, position, velocity, speed limit
// and deceleration level) on the input channel with i_valid; it is taken when
// o_ready is high at the same edge. One force word comes back for every query,
// in order, on o_valid / o_force_* and is taken when i_ready is high.
// The pipeline holds four front stages (offset, magnitude, squares, sum),
// one stage per root bit in the square-root unit (COORD_WIDTH + 1 of them),
// four stages for speed and the offset-times-speed product, one stage per
// quotient bit in the 31-stage divider, and the output register.
// Throughput is one word per cycle while the output is not stalled; every stage holds its own word.
// The whole pipeline advances together: when a result sits in the output
// register and the receiver holds i_ready low, every stage holds and o_ready
// drops, so nothing is lost or repeated. Bubbles move with the valid bits.
// A synchronous low i_rst_n clears all valid bits; data registers keep their
// contents, which is harmless because nothing is flagged valid.
// A zero distance gives a zero force in arrive mode and minus the velocity in
// seek mode; every component saturates to the signed coordinate range.
module steering_seek_arrive #(
    parameter int COORD_WIDTH = ssa_pkg::COORD_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_action,
    input  logic signed [COORD_WIDTH-1:0]         i_target_x,
    input  logic signed [COORD_WIDTH-1:0]         i_target_y,
    input  logic signed [COORD_WIDTH-1:0]         i_target_z,
    input  logic signed [COORD_WIDTH-1:0]         i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]         i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]         i_pos_z,
    input  logic signed [COORD_WIDTH-1:0]         i_vel_x,
    input  logic signed [COORD_WIDTH-1:0]         i_vel_y,
    input  logic signed [COORD_WIDTH-1:0]         i_vel_z,
    input  logic [ssa_pkg::SPEED_WIDTH-1:0]       i_max_speed,
    input  logic [ssa_pkg::DECEL_WIDTH-1:0]       i_decel_level,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [COORD_WIDTH-1:0]         o_force_x,
    output logic signed [COORD_WIDTH-1:0]         o_force_y,
    output logic signed [COORD_WIDTH-1:0]         o_force_z
);

`include "steering_seek_arrive_assert.svh"

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;             // signed offset
    localparam int SQW  = 2 * W;             // one square
    localparam int RW   = W + 1;             // distance
    localparam int SW   = 2 * RW;            // sum of squares
    localparam int SPW  = ssa_pkg::SPEED_WIDTH;
    localparam int DCW  = ssa_pkg::DECEL_WIDTH;
    localparam int XW   = (RW > 33) ? RW : 33;
    localparam int HW   = (W + 1) / 2;       // low half of a magnitude
    localparam int HIW  = W - HW;            // high half of a magnitude
    localparam int NW   = W + SPW;           // dividend
    localparam int FW   = ((W > 32) ? W : 32) + 2;
    localparam int RAWW = 36;                // ten times a 32-bit distance

    // Layout of the side information that rides along the square root.
    localparam int O_DEC = 0;
    localparam int O_MAX = O_DEC + DCW;
    localparam int O_ACT = O_MAX + SPW;
    localparam int O_VEL = O_ACT + 1;
    localparam int O_NEG = O_VEL + 3 * W;
    localparam int O_MAG = O_NEG + 3;
    localparam int SBW   = O_MAG + 3 * W;

    // Only the 64-bit build clamps operands, to plus or minus 2^62.
    localparam logic signed [W-1:0] LIM =
        (W > 63) ? $signed(W'(1) << (W - 2)) : '0;
    localparam logic signed [FW-1:0] SMAX = $signed((FW'(1) << (W - 1)) - FW'(1));
    localparam logic signed [FW-1:0] SMIN = -SMAX - FW'(1);

    function automatic logic signed [W-1:0] f_clamp(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        r = v;
        if (W > 63) begin
            if (v > LIM) begin
                r = LIM;
            end else if (v < -LIM) begin
                r = -LIM;
            end
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] f_sat(input logic signed [FW-1:0] v);
        logic signed [W-1:0] r;
        if (v > SMAX) begin
            r = W'(SMAX);
        end else if (v < SMIN) begin
            r = W'(SMIN);
        end else begin
            r = W'(v);
        end
        return r;
    endfunction

    // The pipeline moves whenever the output register is free or being read.
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    logic signed [W-1:0] w_tgt [3];
    logic signed [W-1:0] w_pos [3];
    logic signed [W-1:0] w_vel [3];

    assign w_tgt[0] = i_target_x;
    assign w_tgt[1] = i_target_y;
    assign w_tgt[2] = i_target_z;
    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;
    assign w_vel[0] = i_vel_x;
    assign w_vel[1] = i_vel_y;
    assign w_vel[2] = i_vel_z;

    // Stage 1: offset from the agent to the target.
    logic                 r1_v;
    logic signed [DW-1:0] r1_d   [3];
    logic signed [W-1:0]  r1_vel [3];
    logic                 r1_act;
    logic [SPW-1:0]       r1_max;
    logic [DCW-1:0]       r1_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_d[k]   <= DW'(f_clamp(w_tgt[k])) - DW'(f_clamp(w_pos[k]));
                r1_vel[k] <= f_clamp(w_vel[k]);
            end
            r1_act <= i_action;
            r1_max <= i_max_speed;
            r1_dec <= i_decel_level;
        end
    end

    // Stage 2: sign and magnitude of each offset component.
    logic                r2_v;
    logic [W-1:0]        r2_mag [3];
    logic                r2_neg [3];
    logic signed [W-1:0] r2_vel [3];
    logic                r2_act;
    logic [SPW-1:0]      r2_max;
    logic [DCW-1:0]      r2_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r2_neg[k] <= r1_d[k][DW-1];
                r2_mag[k] <= W'(r1_d[k][DW-1] ? -r1_d[k] : r1_d[k]);
                r2_vel[k] <= r1_vel[k];
            end
            r2_act <= r1_act;
            r2_max <= r1_max;
            r2_dec <= r1_dec;
        end
    end

    // Everything the later stages need travels packed through the root unit.
    logic [SBW-1:0] w2_side;

    always_comb begin
        w2_side = '0;
        w2_side[O_DEC +: DCW] = r2_dec;
        w2_side[O_MAX +: SPW] = r2_max;
        w2_side[O_ACT]        = r2_act;
        for (int k = 0; k < 3; k++) begin
            w2_side[O_VEL + k * W +: W] = r2_vel[k];
            w2_side[O_NEG + k]          = r2_neg[k];
            w2_side[O_MAG + k * W +: W] = r2_mag[k];
        end
    end

    // Stage 3: squares.
    logic           r3_v;
    logic [SQW-1:0] r3_sq [3];
    logic [SBW-1:0] r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_sq[k] <= SQW'(r2_mag[k]) * SQW'(r2_mag[k]);
            end
            r3_side <= w2_side;
        end
    end

    // Stage 4: squared distance.
    logic           r4_v;
    logic [SW-1:0]  r4_sum;
    logic [SBW-1:0] r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sum  <= SW'(r3_sq[0]) + SW'(r3_sq[1]) + SW'(r3_sq[2]);
            r4_side <= r3_side;
        end
    end

    // Distance, one bit per stage.
    logic           w_rt_v;
    logic [RW-1:0]  w_dist;
    logic [SBW-1:0] w_rt_side;

    ssa_isqrt #(
        .RW  (RW),
        .SBW (SBW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_sq    (r4_sum),
        .i_sb    (r4_side),
        .o_valid (w_rt_v),
        .o_root  (w_dist),
        .o_sb    (w_rt_side)
    );

    // Stage 5: split the distance for the arrive speed and start the
    // divide-by-three multiply. A distance of 2^32 or more always hits the
    // speed limit.
    logic [XW-1:0]  w_dist_x;
    logic           r5_v;
    logic [RW-1:0]  r5_dist;
    logic           r5_big;
    logic           r5_zero;
    logic [31:0]    r5_dl;
    logic [63:0]    r5_p3;
    logic [SBW-1:0] r5_side;

    assign w_dist_x = XW'(w_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= w_rt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_dist <= w_dist;
            r5_big  <= |w_dist_x[XW-1:32];
            r5_zero <= (w_dist == '0);
            r5_dl   <= w_dist_x[31:0];
            r5_p3   <= 64'(w_dist_x[31:0]) * 64'(ssa_pkg::DIV3_MAGIC);
            r5_side <= w_rt_side;
        end
    end

    // Stage 6: speed. Seek runs at the limit; arrive uses distance * 10 /
    // level, capped at the limit. A level of zero also means the limit.
    logic [SPW-1:0]  w5_max;
    logic [DCW-1:0]  w5_dec;
    logic            w5_act;
    logic [30:0]     w5_third;
    logic [RAWW-1:0] w5_raw;
    logic [SPW-1:0]  w5_speed;

    assign w5_max   = r5_side[O_MAX +: SPW];
    assign w5_dec   = r5_side[O_DEC +: DCW];
    assign w5_act   = r5_side[O_ACT];
    assign w5_third = r5_p3[63:ssa_pkg::DIV3_SHIFT];

    always_comb begin
        case (w5_dec)
            ssa_pkg::DECEL_FAST: begin
                w5_raw = RAWW'({r5_dl, 3'b000}) + RAWW'({r5_dl, 1'b0});
            end
            ssa_pkg::DECEL_NORMAL: begin
                w5_raw = RAWW'({r5_dl, 2'b00}) + RAWW'(r5_dl);
            end
            ssa_pkg::DECEL_SLOW: begin
                w5_raw = RAWW'({r5_dl, 1'b0}) + RAWW'(r5_dl) + RAWW'(w5_third);
            end
            default: begin
                w5_raw = RAWW'(w5_max);
            end
        endcase
        if (w5_act == ssa_pkg::ACT_SEEK || r5_big || w5_raw > RAWW'(w5_max)) begin
            w5_speed = w5_max;
        end else begin
            w5_speed = SPW'(w5_raw);
        end
    end

    logic           r6_v;
    logic [SPW-1:0] r6_speed;
    logic [RW-1:0]  r6_dist;
    logic           r6_zero;
    logic [SBW-1:0] r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_speed <= w5_speed;
            r6_dist  <= r5_dist;
            r6_zero  <= r5_zero;
            r6_side  <= r5_side;
        end
    end

    // Stage 7: magnitude times speed, as two half-width products.
    logic               r7_v;
    logic [HW+SPW-1:0]  r7_plo [3];
    logic [HIW+SPW-1:0] r7_phi [3];
    logic [RW-1:0]      r7_dist;
    logic               r7_zero;
    logic [SBW-1:0]     r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r7_plo[k] <= (HW + SPW)'(r6_side[O_MAG + k * W +: HW]) *
                             (HW + SPW)'(r6_speed);
                r7_phi[k] <= (HIW + SPW)'(r6_side[O_MAG + k * W + HW +: HIW]) *
                             (HIW + SPW)'(r6_speed);
            end
            r7_dist <= r6_dist;
            r7_zero <= r6_zero;
            r7_side <= r6_side;
        end
    end

    // Stage 8: recombine the halves into the dividend.
    logic                r8_v;
    logic [NW-1:0]       r8_num [3];
    logic [RW-1:0]       r8_dist;
    logic                r8_zero;
    logic                r8_act;
    logic                r8_neg [3];
    logic signed [W-1:0] r8_vel [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (w_en) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r8_num[k] <= (NW'(r7_phi[k]) << HW) + NW'(r7_plo[k]);
                r8_neg[k] <= r7_side[O_NEG + k];
                r8_vel[k] <= r7_side[O_VEL + k * W +: W];
            end
            r8_dist <= r7_dist;
            r8_zero <= r7_zero;
            r8_act  <= r7_side[O_ACT];
        end
    end

    // Desired speed per axis: |d| * speed / distance, one bit per stage.
    // Lane 0 also carries the mode and the zero-distance flag.
    logic           w_dv [3];
    logic [SPW-1:0] w_quo [3];
    logic [W+2:0]   w_sb0;
    logic [W:0]     w_sb1;
    logic [W:0]     w_sb2;

    ssa_div #(
        .DW  (RW),
        .QW  (SPW),
        .SBW (W + 3)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r8_v),
        .i_num   (r8_num[0]),
        .i_den   (r8_dist),
        .i_sb    ({r8_act, r8_zero, r8_neg[0], r8_vel[0]}),
        .o_valid (w_dv[0]),
        .o_quo   (w_quo[0]),
        .o_sb    (w_sb0)
    );

    ssa_div #(
        .DW  (RW),
        .QW  (SPW),
        .SBW (W + 1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r8_v),
        .i_num   (r8_num[1]),
        .i_den   (r8_dist),
        .i_sb    ({r8_neg[1], r8_vel[1]}),
        .o_valid (w_dv[1]),
        .o_quo   (w_quo[1]),
        .o_sb    (w_sb1)
    );

    ssa_div #(
        .DW  (RW),
        .QW  (SPW),
        .SBW (W + 1)
    ) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r8_v),
        .i_num   (r8_num[2]),
        .i_den   (r8_dist),
        .i_sb    ({r8_neg[2], r8_vel[2]}),
        .o_valid (w_dv[2]),
        .o_quo   (w_quo[2]),
        .o_sb    (w_sb2)
    );

    // Output stage: signed desired velocity minus velocity, saturated; zero in arrive mode at zero distance.
    logic                w_act;
    logic                w_zero;
    logic                w_neg [3];
    logic signed [W-1:0] w_ovel [3];
    logic signed [FW-1:0] w_want [3];
    logic signed [W-1:0] w_force [3];

    assign w_act     = w_sb0[W+2];
    assign w_zero    = w_sb0[W+1];
    assign w_neg[0]  = w_sb0[W];
    assign w_ovel[0] = w_sb0[W-1:0];
    assign w_neg[1]  = w_sb1[W];
    assign w_ovel[1] = w_sb1[W-1:0];
    assign w_neg[2]  = w_sb2[W];
    assign w_ovel[2] = w_sb2[W-1:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (w_zero) begin
                w_want[k] = '0;
            end else if (w_neg[k]) begin
                w_want[k] = -$signed(FW'(w_quo[k]));
            end else begin
                w_want[k] = $signed(FW'(w_quo[k]));
            end
            if (w_zero && w_act == ssa_pkg::ACT_ARRIVE) begin
                w_force[k] = '0;
            end else begin
                w_force[k] = f_sat(w_want[k] - FW'(w_ovel[k]));
            end
        end
    end

    logic                r_out_valid;
    logic signed [W-1:0] r_force [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_force[k] <= w_force[k];
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_force_x = r_force[0];
    assign o_force_y = r_force[1];
    assign o_force_z = r_force[2];

    // The three divider lanes are fed together and must stay in step.
    `SSA_ASSERT_ALWAYS(a_lanes_in_step, (w_dv[0] == w_dv[1]) && (w_dv[0] == w_dv[2]), "lanes")
    // The speed handed to the multipliers never exceeds the agent's limit.
    `SSA_ASSERT_SAME(a_speed_capped, r6_v, r6_speed <= r6_side[O_MAX +: SPW], "speed above limit")
    // An accepted query shows up in the first stage on the next cycle.
    `SSA_ASSERT_NEXT(a_accept_enters, i_valid && o_ready, r1_v, "accepted query dropped")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the seek / arrive steering block.
// Depends on ssa_pkg and steering_seek_arrive; drives directed and random queries.
module tb_top;

    localparam int CW = ssa_pkg::COORD_WIDTH;
    localparam int SPW = ssa_pkg::SPEED_WIDTH;
    localparam int DCW = ssa_pkg::DECEL_WIDTH;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LATENCY = CW + 41;

    typedef struct {
        logic                   action;
        logic signed [CW-1:0]   target[3];
        logic signed [CW-1:0]   pos[3];
        logic signed [CW-1:0]   vel[3];
        logic [SPW-1:0]         max_speed;
        logic [DCW-1:0]         decel;
    } t_query;

    typedef struct {
        logic signed [CW-1:0] f[3];
    } t_force;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, i_action, o_valid, i_ready;
    logic signed [CW-1:0] i_target_x, i_target_y, i_target_z;
    logic signed [CW-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [CW-1:0] i_vel_x, i_vel_y, i_vel_z;
    logic [SPW-1:0] i_max_speed;
    logic [DCW-1:0] i_decel_level;
    logic signed [CW-1:0] o_force_x, o_force_y, o_force_z;

    steering_seek_arrive u_top (.*);

    t_query pending_queries[$];
    t_force expected_forces[$];
    int     error_count = 0;
    int     words_sent = 0;
    int     total_items = 0;
    logic   in_taken = 1'b0;
    bit     held_off = 1'b0;
    int     hold_cycles = 0;
    int     idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Clamp a wide signed value to the signed coordinate range.
    function automatic logic signed [CW-1:0] saturate(longint x);
        longint hi, lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x[CW-1:0];
    endfunction

    // Steering force for one query, computed with exact integer arithmetic.
    function automatic t_force steering_force(t_query q);
        t_force r;
        longint d[3], v[3];
        logic [127:0] mg[3], sumsq, trial, root, quo;
        longint unsigned span, speed;
        sumsq = '0;
        for (int k = 0; k < 3; k++) begin
            d[k] = longint'(q.target[k]) - longint'(q.pos[k]);
            v[k] = longint'(q.vel[k]);
            mg[k] = (d[k] < 0) ? 128'(-d[k]) : 128'(d[k]);
            sumsq += mg[k] * mg[k];
        end
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            trial = root | (128'd1 << i);
            if (trial * trial <= sumsq) root = trial;
        end
        span = root[63:0];
        if (span == 0) begin
            // Degenerate offset: arrive gives no force, seek just cancels velocity.
            for (int k = 0; k < 3; k++)
                r.f[k] = (q.action == ssa_pkg::ACT_ARRIVE) ? '0 : saturate(-v[k]);
            return r;
        end
        if (q.action == ssa_pkg::ACT_SEEK || q.decel == ssa_pkg::DECEL_NONE ||
            span >= (64'd1 << 59)) begin
            speed = q.max_speed;
        end else begin
            speed = span * 10 / q.decel;
            if (speed > q.max_speed) speed = q.max_speed;
        end
        for (int k = 0; k < 3; k++) begin
            quo = (mg[k] * speed) / span;
            if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
            r.f[k] = saturate((d[k] < 0 ? -longint'(quo) : longint'(quo)) - v[k]);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int idx, logic [CW-1:0] got,
                                   logic [CW-1:0] want);
        $display("mismatch %s[%0d]: got %h expected %h", what, idx, got, want);
        error_count++;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(bit near);
        if (near) return CW'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        return CW'($urandom);
    endfunction

    function automatic t_query rand_query();
        t_query q;
        bit near;
        near = ($urandom_range(0, 2) != 0);
        q.action = 1'($urandom_range(0, 1));
        for (int k = 0; k < 3; k++) begin
            q.target[k] = rand_coord(near);
            q.pos[k]    = rand_coord(near);
            q.vel[k]    = rand_coord(near);
        end
        // Small offsets reach the arrive slowdown; occasionally a coincident point.
        if ($urandom_range(0, 19) == 0) q.pos = q.target;
        q.max_speed = near ? SPW'($urandom_range(0, 32'h0080_0000))
                           : SPW'($urandom);
        q.decel = DCW'($urandom_range(0, 3));
        return q;
    endfunction

    function automatic t_query make_query(logic act, logic signed [CW-1:0] t,
                                          logic signed [CW-1:0] p, logic signed [CW-1:0] v,
                                          logic [SPW-1:0] ms, logic [DCW-1:0] dl);
        t_query q;
        q.action = act;
        for (int k = 0; k < 3; k++) begin
            q.target[k] = t;
            q.pos[k] = p;
            q.vel[k] = v;
        end
        q.max_speed = ms;
        q.decel = dl;
        return q;
    endfunction

    // Acceptance on both channels: check the oldest expectation, then queue the new one.
    always @(posedge i_clk) begin
        t_force want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_forces.size() == 0) begin
                    report_mismatch("unexpected force", 0, o_force_x, '0);
                end else begin
                    want = expected_forces.pop_front();
                    if (o_force_x !== want.f[0]) report_mismatch("force", 0, o_force_x, want.f[0]);
                    if (o_force_y !== want.f[1]) report_mismatch("force", 1, o_force_y, want.f[1]);
                    if (o_force_z !== want.f[2]) report_mismatch("force", 2, o_force_z, want.f[2]);
                end
            end
            in_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                t_query q;
                q.action = i_action;
                q.target = '{i_target_x, i_target_y, i_target_z};
                q.pos    = '{i_pos_x, i_pos_y, i_pos_z};
                q.vel    = '{i_vel_x, i_vel_y, i_vel_z};
                q.max_speed = i_max_speed;
                q.decel  = i_decel_level;
                expected_forces.push_back(steering_force(q));
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Driver: the idle rate depends on how far the run has come.
    always @(negedge i_clk) begin
        int idle_pct;
        t_query q;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            idle_pct = (words_sent < total_items / 3) ? 33 :
                       (words_sent < 2 * total_items / 3) ? 69 : 0;
            if (pending_queries.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                q = pending_queries.pop_front();
                words_sent++;
                i_valid <= 1'b1;
                i_action <= q.action;
                i_target_x <= q.target[0]; i_target_y <= q.target[1]; i_target_z <= q.target[2];
                i_pos_x <= q.pos[0]; i_pos_y <= q.pos[1]; i_pos_z <= q.pos[2];
                i_vel_x <= q.vel[0]; i_vel_y <= q.vel[1]; i_vel_z <= q.vel[2];
                i_max_speed <= q.max_speed;
                i_decel_level <= q.decel;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off late in the run that
    // lets the pipeline fill and push back on the sender.
    always @(negedge i_clk) begin
        int idle_pct;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (!held_off && words_sent > 5 * total_items / 6) begin
            held_off <= 1'b1;
            hold_cycles <= 400;
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            idle_pct = (words_sent < total_items / 3) ? 69 :
                       (words_sent < 2 * total_items / 3) ? 33 : 0;
            i_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial begin
        logic signed [CW-1:0] maxc, minc;
        maxc = {1'b0, {(CW-1){1'b1}}};
        minc = {1'b1, {(CW-1){1'b0}}};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_action = ssa_pkg::ACT_SEEK;
        {i_target_x, i_target_y, i_target_z} = '0;
        {i_pos_x, i_pos_y, i_pos_z} = '0;
        {i_vel_x, i_vel_y, i_vel_z} = '0;
        i_max_speed = '0;
        i_decel_level = ssa_pkg::DECEL_FAST;

        // Directed: coincident points in both modes, extreme offsets,
        // saturating velocities, every deceleration level and speed limits.
        pending_queries.push_back(make_query(ssa_pkg::ACT_SEEK, 5, 5, maxc, '1,
                                             ssa_pkg::DECEL_FAST));
        pending_queries.push_back(make_query(ssa_pkg::ACT_SEEK, 0, 0, minc, '1,
                                             ssa_pkg::DECEL_FAST));
        pending_queries.push_back(make_query(ssa_pkg::ACT_ARRIVE, 7, 7, minc, '1,
                                             ssa_pkg::DECEL_SLOW));
        pending_queries.push_back(make_query(ssa_pkg::ACT_SEEK, maxc, minc, 0, '1,
                                             ssa_pkg::DECEL_NORMAL));
        pending_queries.push_back(make_query(ssa_pkg::ACT_ARRIVE, maxc, minc, 0, '1,
                                             ssa_pkg::DECEL_NORMAL));
        pending_queries.push_back(make_query(ssa_pkg::ACT_SEEK, minc, maxc, maxc, '1,
                                             ssa_pkg::DECEL_FAST));
        pending_queries.push_back(make_query(ssa_pkg::ACT_ARRIVE, minc, maxc, minc, '1,
                                             ssa_pkg::DECEL_NONE));
        pending_queries.push_back(make_query(ssa_pkg::ACT_SEEK, maxc, minc, minc, '0,
                                             ssa_pkg::DECEL_SLOW));
        pending_queries.push_back(make_query(ssa_pkg::ACT_ARRIVE, 1, 0, 0, '1,
                                             ssa_pkg::DECEL_FAST));
        pending_queries.push_back(make_query(ssa_pkg::ACT_ARRIVE, 1, 0, 0, '1,
                                             ssa_pkg::DECEL_NORMAL));
        pending_queries.push_back(make_query(ssa_pkg::ACT_ARRIVE, 1, 0, 0, '1,
                                             ssa_pkg::DECEL_SLOW));
        pending_queries.push_back(make_query(ssa_pkg::ACT_ARRIVE, 1, 0, 0, '1,
                                             ssa_pkg::DECEL_NONE));
        pending_queries.push_back(make_query(ssa_pkg::ACT_ARRIVE, 32'h10000, 0, 32'h8000,
                                             31'h2_0000, ssa_pkg::DECEL_NORMAL));
        pending_queries.push_back(make_query(ssa_pkg::ACT_ARRIVE, 32'h1000000, 0, 0,
                                             31'h1_0000, ssa_pkg::DECEL_FAST));
        pending_queries.push_back(make_query(ssa_pkg::ACT_SEEK, -32'sh10000, 32'h10000, -1,
                                             31'h1_0000, ssa_pkg::DECEL_FAST));
        pending_queries.push_back(make_query(ssa_pkg::ACT_ARRIVE, -1, 0, 1, 0,
                                             ssa_pkg::DECEL_SLOW));
        for (int n = 0; n < 1700; n++) pending_queries.push_back(rand_query());
        total_items = pending_queries.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_queries.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_forces.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0 && expected_forces.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
